@@ hdl/ipnfd_pkg.sv @@
// Shared constants, types and helper functions for the infrared nibble frame decoder.
`timescale 1ns / 1ps

package ipnfd_pkg;

    localparam int NIBBLES_PER_SECTION = 8;

    localparam int DUR_W   = 18;
    localparam int CMP_W   = DUR_W + 1;
    localparam int TOL_W   = 8;
    localparam int GAP_W   = 17;
    localparam int WORD_W  = 32;
    localparam int POS_W   = 6;
    localparam int NIB_W   = 4;
    localparam int NUM_NIB = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam int MARK_NOMINAL = 180;
    localparam int SPACE_BASE   = 786;
    localparam int SPACE_STEP   = 137;
    localparam int SPACE_HALF   = 68;
    localparam int LAST_GAP_MIN = 12900;

    localparam logic [TOL_W-1:0] MARK_TOL_RESET = TOL_W'(100);
    localparam logic [GAP_W-1:0] GAP_MIN_RESET  = GAP_W'(9750);
    localparam logic [GAP_W-1:0] GAP_MAX_RESET  = GAP_W'(16250);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MARK_TOL = 2'd0,
        REG_GAP_MIN  = 2'd1,
        REG_GAP_MAX  = 2'd2
    } cfg_reg_t;

    // Classification of one duration, handed from the pulse checker to the tracker.
    typedef struct packed {
        logic             mark_ok;
        logic             nibble_ok;
        logic [NIB_W-1:0] nibble;
        logic             gap_ok;
        logic             last_gap_ok;
    } pulse_class_t;

    // Lower (most negative) bound of the space window for nibble v.
    function automatic logic signed [CMP_W-1:0] space_lo(input int v);
        return CMP_W'(-(SPACE_BASE + SPACE_HALF + SPACE_STEP * v));
    endfunction

    // Upper (least negative) bound of the space window for nibble v.
    function automatic logic signed [CMP_W-1:0] space_hi(input int v);
        return CMP_W'(-(SPACE_BASE - SPACE_HALF + SPACE_STEP * v));
    endfunction

    // The low nibble must equal the inverted low four bits of 15 plus the other seven nibbles.
    function automatic logic checksum_ok(input logic [WORD_W-1:0] w);
        logic [NIB_W-1:0] sum;
        sum = 4'hF;
        for (int i = 1; i < WORD_W / NIB_W; i++) begin
            sum = sum + w[i*NIB_W +: NIB_W];
        end
        return (~sum) == w[NIB_W-1:0];
    endfunction

endpackage

@@ hdl/ipnfd_pulse_check.sv @@
// Parallel window compares that classify one pulse duration.
`timescale 1ns / 1ps

module ipnfd_pulse_check (
    input  logic signed [ipnfd_pkg::DUR_W-1:0] duration_us,
    input  logic [ipnfd_pkg::TOL_W-1:0]        mark_tol,
    input  logic [ipnfd_pkg::GAP_W-1:0]        gap_min,
    input  logic [ipnfd_pkg::GAP_W-1:0]        gap_max,
    output ipnfd_pkg::pulse_class_t            pulse_class
);

    localparam int CMP_W = ipnfd_pkg::CMP_W;

    logic signed [CMP_W-1:0] dur_ext;
    logic signed [CMP_W-1:0] dur_neg;
    logic signed [CMP_W-1:0] tol_ext;
    logic signed [CMP_W-1:0] mark_lo;
    logic signed [CMP_W-1:0] mark_hi;
    logic signed [CMP_W-1:0] gmin_ext;
    logic signed [CMP_W-1:0] gmax_ext;
    logic [ipnfd_pkg::NUM_NIB-1:0] win_hit;

    assign dur_ext  = CMP_W'(duration_us);
    assign dur_neg  = -dur_ext;
    assign tol_ext  = signed'({{(CMP_W - ipnfd_pkg::TOL_W){1'b0}}, mark_tol});
    assign mark_lo  = CMP_W'(ipnfd_pkg::MARK_NOMINAL) - tol_ext;
    assign mark_hi  = CMP_W'(ipnfd_pkg::MARK_NOMINAL) + tol_ext;
    assign gmin_ext = signed'({{(CMP_W - ipnfd_pkg::GAP_W){1'b0}}, gap_min});
    assign gmax_ext = signed'({{(CMP_W - ipnfd_pkg::GAP_W){1'b0}}, gap_max});

    always_comb begin
        for (int v = 0; v < ipnfd_pkg::NUM_NIB; v++) begin
            win_hit[v] = (dur_ext >= ipnfd_pkg::space_lo(v)) &&
                         (dur_ext <= ipnfd_pkg::space_hi(v));
        end
    end

    always_comb begin
        pulse_class.mark_ok     = (dur_ext >= mark_lo) && (dur_ext <= mark_hi);
        pulse_class.gap_ok      = (dur_ext < 0) && (dur_neg >= gmin_ext) &&
                                  (dur_neg <= gmax_ext);
        pulse_class.last_gap_ok = dur_ext <= CMP_W'(-ipnfd_pkg::LAST_GAP_MIN);
        pulse_class.nibble_ok   = |win_hit;
        pulse_class.nibble      = '0;
        // Lowest matching window wins; scanning downward leaves it last.
        for (int v = ipnfd_pkg::NUM_NIB - 1; v >= 0; v--) begin
            if (win_hit[v]) begin
                pulse_class.nibble = ipnfd_pkg::NIB_W'(v);
            end
        end
    end

endmodule

@@ hdl/ipnfd_frame_track.sv @@
// Frame position, nibble shift registers and error tracking with end-of-frame verdict.
`timescale 1ns / 1ps

module ipnfd_frame_track #(
    parameter int NIBBLES_PER_SECTION = ipnfd_pkg::NIBBLES_PER_SECTION
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               item_fire,
    input  logic                               frame_start,
    input  logic                               frame_end,
    input  ipnfd_pkg::pulse_class_t            pulse_class,
    output logic                               res_valid,
    output logic [ipnfd_pkg::WORD_W-1:0]       res_address,
    output logic [ipnfd_pkg::WORD_W-1:0]       res_command
);

    localparam int POS_W  = ipnfd_pkg::POS_W;
    localparam int WORD_W = ipnfd_pkg::WORD_W;
    localparam int NIB_W  = ipnfd_pkg::NIB_W;
    localparam logic [POS_W-1:0] PAIR_LEN    = POS_W'(2 * NIBBLES_PER_SECTION);
    localparam logic [POS_W-1:0] SECTION_LEN = POS_W'(2 * NIBBLES_PER_SECTION + 2);
    localparam logic [POS_W-1:0] FRAME_LEN   = POS_W'(4 * NIBBLES_PER_SECTION + 4);

    logic [POS_W-1:0]  pos_reg, pos_next, pos_eff, offset;
    logic [WORD_W-1:0] addr_reg, addr_next, addr_eff;
    logic [WORD_W-1:0] cmd_reg, cmd_next, cmd_eff;
    logic              err_reg, err_next, err_eff;
    logic              second_section;
    logic [NIB_W-1:0]  nib;
    logic              verdict;

    always_comb begin
        // A start flag discards whatever was collected before this item.
        pos_eff  = frame_start ? '0 : pos_reg;
        addr_eff = frame_start ? '0 : addr_reg;
        cmd_eff  = frame_start ? '0 : cmd_reg;
        err_eff  = frame_start ? 1'b0 : err_reg;

        second_section = pos_eff >= SECTION_LEN;
        offset = second_section ? pos_eff - SECTION_LEN : pos_eff;
        nib    = pulse_class.nibble_ok ? pulse_class.nibble : '0;

        addr_next = addr_eff;
        cmd_next  = cmd_eff;
        err_next  = err_eff;

        priority if (pos_eff >= FRAME_LEN) begin
            err_next = 1'b1;
        end else if (offset < PAIR_LEN) begin
            if (!offset[0]) begin
                err_next = err_eff | ~pulse_class.mark_ok;
            end else begin
                err_next = err_eff | ~pulse_class.nibble_ok;
                if (second_section) begin
                    cmd_next = {cmd_eff[WORD_W-NIB_W-1:0], nib};
                end else begin
                    addr_next = {addr_eff[WORD_W-NIB_W-1:0], nib};
                end
            end
        end else if (offset == PAIR_LEN) begin
            err_next = err_eff | ~pulse_class.mark_ok;
        end else if (!second_section) begin
            err_next = err_eff | ~pulse_class.gap_ok;
        end else begin
            err_next = err_eff | ~pulse_class.last_gap_ok;
        end

        pos_next = (pos_eff < FRAME_LEN + POS_W'(1)) ? pos_eff + POS_W'(1) : pos_eff;

        verdict = !err_next && (pos_next == FRAME_LEN) &&
                  ipnfd_pkg::checksum_ok(addr_next) && ipnfd_pkg::checksum_ok(cmd_next);

        res_valid   = verdict;
        res_address = verdict ? addr_next : '0;
        res_command = verdict ? cmd_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            addr_reg <= '0;
            cmd_reg  <= '0;
            err_reg  <= 1'b0;
        end else if (item_fire) begin
            if (frame_end) begin
                pos_reg  <= '0;
                addr_reg <= '0;
                cmd_reg  <= '0;
                err_reg  <= 1'b0;
            end else begin
                pos_reg  <= pos_next;
                addr_reg <= addr_next;
                cmd_reg  <= cmd_next;
                err_reg  <= err_next;
            end
        end
    end

endmodule

@@ hdl/ir_pulse_nibble_frame_decoder_top.sv @@
// Top level of the infrared nibble frame decoder: input register, configuration and result register.
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// s_        s_valid / s_ready    s_duration_us, s_frame_start, s_frame_end
// m_        m_valid / m_ready    m_frame_valid, m_address_word, m_command_word
// cfg_      cfg_wr_en            cfg_index, cfg_wdata
//
// Each transaction on s_ is captured in an input register; from there it is classified
// by parallel window compares and folded into the frame state, one transaction per cycle
// unless an end-of-frame transaction is waiting on a stalled m_ side. A transaction carrying
// frame_end loads the result register when it is folded in, and m_ is driven from that
// register. Reset is synchronous and active low and restores the default configuration and
// an empty frame. A stalled m_ side holds only end-of-frame transactions; all other
// durations keep flowing while a result waits to be taken.

module ir_pulse_nibble_frame_decoder_top #(
    parameter int NIBBLES_PER_SECTION = ipnfd_pkg::NIBBLES_PER_SECTION
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [ipnfd_pkg::DUR_W-1:0]   s_duration_us,
    input  logic                                 s_frame_start,
    input  logic                                 s_frame_end,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_frame_valid,
    output logic [ipnfd_pkg::WORD_W-1:0]         m_address_word,
    output logic [ipnfd_pkg::WORD_W-1:0]         m_command_word,

    input  logic                                 cfg_wr_en,
    input  logic [ipnfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ipnfd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // Configuration registers.
    logic [ipnfd_pkg::TOL_W-1:0] mark_tol_reg;
    logic [ipnfd_pkg::GAP_W-1:0] gap_min_reg;
    logic [ipnfd_pkg::GAP_W-1:0] gap_max_reg;

    // Input register holding one accepted transaction.
    logic                                in_valid_reg;
    logic signed [ipnfd_pkg::DUR_W-1:0]  dur_reg;
    logic                                start_reg;
    logic                                end_reg;

    // Result register.
    logic                                out_valid_reg;
    logic                                out_frame_valid_reg;
    logic [ipnfd_pkg::WORD_W-1:0]        out_address_reg;
    logic [ipnfd_pkg::WORD_W-1:0]        out_command_reg;

    logic                                out_free;
    logic                                item_fire;
    ipnfd_pkg::pulse_class_t             pulse_class;
    logic                                res_valid;
    logic [ipnfd_pkg::WORD_W-1:0]        res_address;
    logic [ipnfd_pkg::WORD_W-1:0]        res_command;

    // An item without frame_end never needs the result register, so only end items wait on it.
    assign out_free  = !out_valid_reg || m_ready;
    assign item_fire = in_valid_reg && (!end_reg || out_free);
    assign s_ready   = !in_valid_reg || item_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mark_tol_reg <= ipnfd_pkg::MARK_TOL_RESET;
            gap_min_reg  <= ipnfd_pkg::GAP_MIN_RESET;
            gap_max_reg  <= ipnfd_pkg::GAP_MAX_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ipnfd_pkg::REG_MARK_TOL: mark_tol_reg <= cfg_wdata[ipnfd_pkg::TOL_W-1:0];
                ipnfd_pkg::REG_GAP_MIN:  gap_min_reg  <= cfg_wdata[ipnfd_pkg::GAP_W-1:0];
                ipnfd_pkg::REG_GAP_MAX:  gap_max_reg  <= cfg_wdata[ipnfd_pkg::GAP_W-1:0];
                default: ;  // Unmapped index: the write is dropped.
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            dur_reg   <= s_duration_us;
            start_reg <= s_frame_start;
            end_reg   <= s_frame_end;
        end
    end

    ipnfd_pulse_check u_pulse_check (
        .duration_us (dur_reg),
        .mark_tol    (mark_tol_reg),
        .gap_min     (gap_min_reg),
        .gap_max     (gap_max_reg),
        .pulse_class (pulse_class)
    );

    ipnfd_frame_track #(
        .NIBBLES_PER_SECTION (NIBBLES_PER_SECTION)
    ) u_frame_track (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_fire   (item_fire),
        .frame_start (start_reg),
        .frame_end   (end_reg),
        .pulse_class (pulse_class),
        .res_valid   (res_valid),
        .res_address (res_address),
        .res_command (res_command)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (item_fire && end_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_fire && end_reg) begin
            out_frame_valid_reg <= res_valid;
            out_address_reg     <= res_address;
            out_command_reg     <= res_command;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_frame_valid  = out_frame_valid_reg;
    assign m_address_word = out_address_reg;
    assign m_command_word = out_command_reg;

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the infrared nibble frame decoder: pulse frames in, decodes checked.
`timescale 1ns / 1ps

module tb;
    import ipnfd_pkg::*;

    // Frame geometry: per section, N mark/space pairs, then a footer mark and a footer space.
    localparam int SECTION_LEN = 2 * NIBBLES_PER_SECTION + 2;
    localparam int FRAME_LEN   = 2 * SECTION_LEN;
    localparam int DUR_MIN     = -(2 ** (DUR_W - 1));
    localparam int DUR_MAX     = 2 ** (DUR_W - 1) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTED = 60;

    // One duration as it goes over the input channel.
    typedef struct {
        logic signed [DUR_W-1:0] dur;
        bit                      start;
        bit                      stop;
    } pulse_item_t;

    // One decode as it comes out of the result channel.
    typedef struct packed {
        logic              frame_valid;
        logic [WORD_W-1:0] address_word;
        logic [WORD_W-1:0] command_word;
    } decode_result_t;

    // How a generated burst differs from a clean frame.
    typedef enum int {
        SHAPE_CLEAN,
        SHAPE_LOW_MARKS,
        SHAPE_BAD_CHECKSUM,
        SHAPE_BAD_PULSE,
        SHAPE_SHORT,
        SHAPE_LONG,
        SHAPE_EARLY_END,
        SHAPE_NO_START,
        SHAPE_NO_END,
        SHAPE_RESTART,
        SHAPE_NOISE
    } frame_shape_t;

    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    s_valid       = 1'b0;
    logic                    s_ready;
    logic signed [DUR_W-1:0] s_duration_us = '0;
    logic                    s_frame_start = 1'b0;
    logic                    s_frame_end   = 1'b0;
    logic                    m_valid;
    logic                    m_ready       = 1'b0;
    logic                    m_frame_valid;
    logic [WORD_W-1:0]       m_address_word;
    logic [WORD_W-1:0]       m_command_word;
    logic                    cfg_wr_en     = 1'b0;
    cfg_reg_t                cfg_index     = REG_MARK_TOL;
    logic [CFG_DATA_W-1:0]   cfg_wdata     = '0;

    // Shadow copy of the configuration registers, as the block should hold them.
    int tol_cfg    = MARK_TOL_RESET;
    int gap_lo_cfg = GAP_MIN_RESET;
    int gap_hi_cfg = GAP_MAX_RESET;

    // Shadow copy of the frame tracker.
    int                frame_pos = 0;
    logic [WORD_W-1:0] addr_acc  = '0;
    logic [WORD_W-1:0] cmd_acc   = '0;
    bit                frame_bad = 1'b0;

    decode_result_t expected_decodes[$];
    pulse_item_t    frame_buf[$];

    int items_sent        = 0;
    int error_count       = 0;
    int cycle_count       = 0;
    int stall_left        = 0;
    bit idling_on         = 1'b1;
    bit gaps_on           = 1'b1;

    always #4 aclk = ~aclk;

    ir_pulse_nibble_frame_decoder_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_duration_us  (s_duration_us),
        .s_frame_start  (s_frame_start),
        .s_frame_end    (s_frame_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_valid  (m_frame_valid),
        .m_address_word (m_address_word),
        .m_command_word (m_command_word),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Decode prediction
    // ------------------------------------------------------------------

    // A word is good when its low nibble is the inverted low four bits of
    // 15 plus the seven upper nibbles.
    function automatic bit sum_nibble_ok(input logic [WORD_W-1:0] w);
        int acc;
        acc = 15;
        for (int i = 1; i < 8; i++) acc += w[4*i +: 4];
        return ((acc & 15) ^ 15) == w[3:0];
    endfunction

    function automatic bit mark_fits(input int d);
        return d >= MARK_NOMINAL - tol_cfg && d <= MARK_NOMINAL + tol_cfg;
    endfunction

    function automatic void clear_frame();
        frame_pos = 0;
        addr_acc  = '0;
        cmd_acc   = '0;
        frame_bad = 1'b0;
    endfunction

    // Folds one accepted duration into the shadow tracker and queues the
    // decode that a frame_end transaction is due to produce.
    function automatic void absorb_pulse(input pulse_item_t it);
        int             d;
        int             sect;
        int             off;
        int             nib;
        bit             good;
        decode_result_t r;
        d = it.dur;
        if (it.start) clear_frame();
        if (frame_pos >= FRAME_LEN) begin
            frame_bad = 1'b1;
        end else begin
            sect = frame_pos / SECTION_LEN;
            off  = frame_pos % SECTION_LEN;
            if (off < 2 * NIBBLES_PER_SECTION) begin
                if (off % 2 == 0) begin
                    if (!mark_fits(d)) frame_bad = 1'b1;
                end else begin
                    // The space windows are contiguous, so the first hit is the only one.
                    nib = -1;
                    for (int v = 0; v < 16; v++) begin
                        if (nib < 0 && d <= 0 &&
                            d >= -(SPACE_BASE + SPACE_HALF + SPACE_STEP * v) &&
                            d <= -(SPACE_BASE - SPACE_HALF + SPACE_STEP * v))
                            nib = v;
                    end
                    if (nib < 0) begin
                        frame_bad = 1'b1;
                        nib = 0;
                    end
                    if (sect == 0) addr_acc = {addr_acc[WORD_W-5:0], 4'(nib)};
                    else           cmd_acc  = {cmd_acc[WORD_W-5:0], 4'(nib)};
                end
            end else if (off == 2 * NIBBLES_PER_SECTION) begin
                if (!mark_fits(d)) frame_bad = 1'b1;
            end else if (sect == 0) begin
                if (!(d < 0 && -d >= gap_lo_cfg && -d <= gap_hi_cfg)) frame_bad = 1'b1;
            end else begin
                if (!(d <= -LAST_GAP_MIN)) frame_bad = 1'b1;
            end
        end
        if (frame_pos < FRAME_LEN + 1) frame_pos++;

        if (it.stop) begin
            good = !frame_bad && frame_pos == FRAME_LEN &&
                   sum_nibble_ok(addr_acc) && sum_nibble_ok(cmd_acc);
            r.frame_valid  = good;
            r.address_word = good ? addr_acc : '0;
            r.command_word = good ? cmd_acc : '0;
            expected_decodes.push_back(r);
            clear_frame();
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    // Uniform in [lo, hi], with both edges picked more often.
    function automatic int pick_in(input int lo, input int hi);
        if (hi <= lo) return lo;
        case ($urandom_range(0, 7))
            0:       return lo;
            1:       return hi;
            default: return lo + int'($urandom_range(hi - lo, 0));
        endcase
    endfunction

    function automatic logic signed [DUR_W-1:0] noise_dur();
        case ($urandom_range(0, 4))
            0: return DUR_W'($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0:       return DUR_W'(DUR_MIN);
                    1:       return DUR_W'(DUR_MAX);
                    2:       return '0;
                    default: return DUR_W'(-1);
                endcase
            end
            2:       return DUR_W'(pick_in(-400, 600));
            3:       return DUR_W'(pick_in(-3000, -500));
            default: return DUR_W'(pick_in(DUR_MIN, -9000));
        endcase
    endfunction

    // Random word with a correct checksum nibble.
    function automatic logic [WORD_W-1:0] make_word();
        logic [WORD_W-1:0] w;
        int                acc;
        w   = $urandom;
        acc = 15;
        for (int i = 1; i < 8; i++) acc += w[4*i +: 4];
        w[3:0] = 4'((acc & 15) ^ 15);
        return w;
    endfunction

    function automatic void add_pulse(input int d);
        pulse_item_t it;
        it.dur   = DUR_W'(d);
        it.start = 1'b0;
        it.stop  = 1'b0;
        frame_buf.push_back(it);
    endfunction

    // Fills frame_buf with a frame for the two words; it fits the settings if gap min <= max.
    function automatic void build_frame(input logic [WORD_W-1:0] addr,
                                        input logic [WORD_W-1:0] cmd);
        logic [WORD_W-1:0] w;
        int                v;
        frame_buf.delete();
        for (int sect = 0; sect < 2; sect++) begin
            w = (sect == 0) ? addr : cmd;
            for (int n = 0; n < NIBBLES_PER_SECTION; n++) begin
                v = w[WORD_W-1-4*n -: 4];
                add_pulse(pick_in(MARK_NOMINAL - tol_cfg, MARK_NOMINAL + tol_cfg));
                add_pulse(pick_in(-(SPACE_BASE + SPACE_HALF + SPACE_STEP * v),
                                  -(SPACE_BASE - SPACE_HALF + SPACE_STEP * v)));
            end
            add_pulse(pick_in(MARK_NOMINAL - tol_cfg, MARK_NOMINAL + tol_cfg));
            if (sect == 1)
                add_pulse(pick_in(DUR_MIN, -LAST_GAP_MIN));
            else if (gap_lo_cfg <= gap_hi_cfg)
                add_pulse(-pick_in(gap_lo_cfg, gap_hi_cfg));
            else
                add_pulse(-pick_in(gap_hi_cfg, gap_lo_cfg));
        end
        frame_buf[0].start = 1'b1;
        frame_buf[frame_buf.size()-1].stop = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Offers one transaction on the input channel and waits until it is taken.
    // Called at a rising edge; valid stays high between back-to-back transactions.
    task automatic send_pulse(input pulse_item_t it);
        if (idling_on && gaps_on && $urandom_range(0, 2) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_duration_us <= it.dur;
        s_frame_start <= it.start;
        s_frame_end   <= it.stop;
        do @(posedge aclk); while (s_ready !== 1'b1);
        absorb_pulse(it);
        items_sent++;
    endtask

    // Stops sending, waits for every queued decode, then for the pipeline to empty.
    task automatic wait_for_drain(input int extra);
        s_valid <= 1'b0;
        while (expected_decodes.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= which;
        cfg_wdata <= data;
        @(posedge aclk);
        case (which)
            REG_MARK_TOL: tol_cfg    = data[TOL_W-1:0];
            REG_GAP_MIN:  gap_lo_cfg = data[GAP_W-1:0];
            REG_GAP_MAX:  gap_hi_cfg = data[GAP_W-1:0];
            default: ;
        endcase
    endtask

    // Rewrites all three registers once the block has gone quiet. The unused upper
    // bits of the tolerance write carry junk half the time; only the low byte counts.
    task automatic load_settings(input int tol, input int gap_lo, input int gap_hi);
        logic [CFG_DATA_W-1:0] tol_word;
        wait_for_drain(4);
        tol_word = CFG_DATA_W'($urandom);
        if ($urandom_range(0, 1) == 0) tol_word[CFG_DATA_W-1:TOL_W] = '0;
        tol_word[TOL_W-1:0] = TOL_W'(tol);
        write_reg(REG_MARK_TOL, tol_word);
        write_reg(REG_GAP_MIN, CFG_DATA_W'(gap_lo));
        write_reg(REG_GAP_MAX, CFG_DATA_W'(gap_hi));
        cfg_wr_en <= 1'b0;
    endtask

    // Builds one burst of the given shape and sends it transaction by transaction.
    task automatic send_frame(input frame_shape_t shape);
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] cmd;
        pulse_item_t       it;
        pulse_item_t       prefix[$];
        int                idx;
        int                k;
        addr = make_word();
        cmd  = make_word();
        if (shape == SHAPE_BAD_CHECKSUM) begin
            if ($urandom_range(0, 1) == 0) addr[3:0] ^= 4'($urandom_range(1, 15));
            else                           cmd[3:0]  ^= 4'($urandom_range(1, 15));
        end
        build_frame(addr, cmd);

        case (shape)
            SHAPE_LOW_MARKS: begin
                // Every mark at the lowest accepted length; with a tolerance
                // above the nominal mark this is a short space.
                foreach (frame_buf[i]) begin
                    k = i % SECTION_LEN;
                    if (k <= 2 * NIBBLES_PER_SECTION && k % 2 == 0)
                        frame_buf[i].dur = DUR_W'(MARK_NOMINAL - tol_cfg);
                end
            end
            SHAPE_BAD_PULSE: begin
                idx = $urandom_range(0, FRAME_LEN - 1);
                if ($urandom_range(0, 1) == 0)
                    frame_buf[idx].dur = noise_dur();
                else
                    frame_buf[idx].dur = DUR_W'(int'(frame_buf[idx].dur) + pick_in(-90, 90));
            end
            SHAPE_SHORT: begin
                repeat ($urandom_range(1, 3))
                    frame_buf.delete($urandom_range(1, frame_buf.size() - 2));
            end
            SHAPE_LONG: begin
                // Too many durations: extra transactions slip in before the last one.
                repeat ($urandom_range(1, 3)) begin
                    it.dur   = noise_dur();
                    it.start = 1'b0;
                    it.stop  = 1'b0;
                    frame_buf.insert(frame_buf.size() - 1, it);
                end
            end
            SHAPE_EARLY_END: begin
                k = $urandom_range(0, FRAME_LEN - 2);
                while (frame_buf.size() > k + 1) void'(frame_buf.pop_back());
                frame_buf[k].stop = 1'b1;
            end
            SHAPE_NO_START: frame_buf[0].start = 1'b0;
            SHAPE_NO_END:   frame_buf[FRAME_LEN-1].stop = 1'b0;
            SHAPE_RESTART: begin
                // An aborted beginning, then the whole frame restarted with frame_start.
                k = $urandom_range(1, FRAME_LEN - 6);
                for (int i = 0; i < k; i++) prefix.push_back(frame_buf[i]);
                for (int i = k - 1; i >= 0; i--) frame_buf.push_front(prefix[i]);
            end
            SHAPE_NOISE: begin
                frame_buf.delete();
                repeat ($urandom_range(1, 12)) begin
                    it.dur   = noise_dur();
                    it.start = ($urandom_range(0, 7) == 0);
                    it.stop  = ($urandom_range(0, 5) == 0);
                    frame_buf.push_back(it);
                end
                frame_buf[frame_buf.size()-1].stop = 1'b1;
            end
            default: ;
        endcase

        foreach (frame_buf[i]) send_pulse(frame_buf[i]);
    endtask

    function automatic frame_shape_t random_shape();
        int r;
        r = $urandom_range(0, 19);
        // About half the bursts are clean frames; the rest spread over the other shapes.
        return (r < 10) ? SHAPE_CLEAN : frame_shape_t'(r - 9);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Single transactions: field extremes, a duration before any frame_start,
    // frame_end without frame_start, and a two-item burst.
    task automatic test_lone_pulses();
        int          durs[9]   = '{DUR_MAX, DUR_MIN, 0, 180, 1, -1, -854, DUR_MIN, DUR_MAX};
        bit          starts[9] = '{0, 1, 1, 0, 1, 1, 0, 0, 1};
        bit          stops[9]  = '{1, 1, 0, 1, 1, 1, 1, 0, 1};
        pulse_item_t it;
        for (int i = 0; i < 9; i++) begin
            it.dur   = DUR_W'(durs[i]);
            it.start = starts[i];
            it.stop  = stops[i];
            send_pulse(it);
        end
    endtask

    task automatic test_clean_frames();
        repeat (1) send_frame(SHAPE_CLEAN);
    endtask

    // Length, framing and checksum cases at the reset settings.
    task automatic test_frame_cases();
        send_frame(SHAPE_LONG);
        send_frame(SHAPE_RESTART);
        send_frame(SHAPE_EARLY_END);
        send_frame(SHAPE_NO_START);
        send_frame(SHAPE_BAD_CHECKSUM);
        send_frame(SHAPE_SHORT);
        // A frame left open, then one without frame_start that overruns it.
        send_frame(SHAPE_NO_END);
        send_frame(SHAPE_NO_START);
    endtask

    task automatic test_register_extremes();
        load_settings(0, GAP_MIN_RESET, GAP_MAX_RESET);
        send_frame(SHAPE_CLEAN);
        send_frame(SHAPE_BAD_PULSE);
        load_settings(255, 0, 131071);
        send_frame(SHAPE_LOW_MARKS);
        load_settings(181, 13000, 13000);
        send_frame(SHAPE_CLEAN);
        // Gap minimum above the maximum: no first footer space can pass.
        load_settings(100, 16251, 16250);
        send_frame(SHAPE_CLEAN);
        load_settings(1, 131071, 131071);
        send_frame(SHAPE_CLEAN);
    endtask

    // Mostly well-formed frames with random content, in phases of random settings.
    task automatic test_random_traffic();
        int frames_left;
        int lo;
        frames_left = 0;
        while (items_sent < 600) begin
            if (frames_left == 0) begin
                case ($urandom_range(0, 3))
                    0: load_settings(MARK_TOL_RESET, GAP_MIN_RESET, GAP_MAX_RESET);
                    3: load_settings($urandom_range(0, 255), $urandom_range(0, 131071),
                                     $urandom_range(0, 131071));
                    default: begin
                        lo = $urandom_range(0, 30000);
                        load_settings($urandom_range(20, 255), lo, lo + $urandom_range(0, 30000));
                    end
                endcase
                frames_left = $urandom_range(4, 10);
            end
            gaps_on = ($urandom_range(0, 3) != 0);
            send_frame(random_shape());
            frames_left--;
        end
        gaps_on = 1'b1;
    endtask

    // Last stretch at full rate on both channels.
    task automatic test_full_rate();
        idling_on = 1'b0;
        repeat (2) send_frame(random_shape());
    endtask

    // ------------------------------------------------------------------
    // Result checking and result-side stalls
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : result_monitor
        decode_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (expected_decodes.size() == 0) begin
                error_count++;
                if (error_count <= MAX_PRINTED)
                    $display("%0t: result with none expected, expected none, got %0b %h %h",
                             $time, m_frame_valid, m_address_word, m_command_word);
            end else begin
                want = expected_decodes.pop_front();
                if (m_frame_valid !== want.frame_valid) begin
                    error_count++;
                    if (error_count <= MAX_PRINTED)
                        $display("%0t: frame_valid mismatch, expected %0b, got %0b",
                                 $time, want.frame_valid, m_frame_valid);
                end
                if (m_address_word !== want.address_word) begin
                    error_count++;
                    if (error_count <= MAX_PRINTED)
                        $display("%0t: address_word mismatch, expected %h, got %h",
                                 $time, want.address_word, m_address_word);
                end
                if (m_command_word !== want.command_word) begin
                    error_count++;
                    if (error_count <= MAX_PRINTED)
                        $display("%0t: command_word mismatch, expected %h, got %h",
                                 $time, want.command_word, m_command_word);
                end
            end
        end

        // Ready drops now and then for a random stretch, except while idling or gaps are off.
        if (!(idling_on && gaps_on)) begin
            stall_left = 0;
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 13);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        // Reset is held from the start and released once.
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_lone_pulses();
        test_clean_frames();
        test_frame_cases();
        test_register_extremes();
        test_random_traffic();
        test_full_rate();

        wait_for_drain(8);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
